// File: hdl/escc_pkg.sv
package escc_pkg;
	localparam int RELOAD_W = 20;
	localparam logic [RELOAD_W-1:0] RELOAD_RESET = 20'd32767;
	localparam logic [11:0] EPOCH_YEAR = 12'd1970;
	localparam logic [11:0] LAST_SET_YEAR = 12'd2099;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_YEAR = 2'd1;
	localparam logic [1:0] ST_BAD_MONTH = 2'd2;

	typedef struct packed {
		logic        func;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [31:0] seconds;
		logic [19:0] divider;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] seconds;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [9:0]  msec;
	} out_word_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic step;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic done;
	} dp_sts_t;

	// years walked by the datapath stay within 1970..2106, where the only
	// century years are 2000 (leap) and 2100 (not leap)
	function automatic logic is_leap(input logic [11:0] y);
		is_leap = (y[1:0] == 2'd0) && (y != 12'd2100);
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		case (m)
			4'd1: month_days = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: month_days = 5'd30;
			default: month_days = 5'd31;
		endcase
	endfunction
endpackage

// File: hdl/epoch_seconds_calendar_converter_top.sv
// channel | dir | payload
// s_*     | in  | tdata: func,year_in,month_in,day_in,hour_in,minute_in,
//         |     |        second_in,seconds_in,divider_in
// m_*     | out | tdata: status,seconds_out,year_out,month_out,day_out,hour_out,minute_out,
//         |     |        second_out,millisecond_out
// apb     | in  | prescaler_reload at 0x0
// Mode 0: seconds are summed year by year, then month by month; a reject skips both loops.
// Mode 1: day split, time of day, years, months, then the millisecond divide.
// The year loop is the longest phase; s_tready returns once the result is loaded out.
// One word at a time; a result held by m_tready stalls the controller until the output
// register frees, then the output register holds it while the next word is taken.
// arst_n clears control and sets the reload register to 32767.
module epoch_seconds_calendar_converter_top import escc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata, // func,year,month,day,hour,minute,second,seconds,divider
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [87:0]  m_tdata, // status,seconds,year,month,day,hour,minute,second,ms
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	logic [RELOAD_W-1:0] reload_q;
	in_word_t  din;
	out_word_t dout, out_q;
	dp_cmd_t   cmd;
	dp_sts_t   sts;
	logic busy, out_load, in_fire, out_free;

	assign din.func = s_tdata[0];
	assign din.year = s_tdata[12:1];
	assign din.month = s_tdata[16:13];
	assign din.day = s_tdata[21:17];
	assign din.hour = s_tdata[26:22];
	assign din.minute = s_tdata[32:27];
	assign din.second = s_tdata[38:33];
	assign din.seconds = s_tdata[70:39];
	assign din.divider = s_tdata[90:71];

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {12'd0, reload_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) reload_q <= RELOAD_RESET;
		else if (psel && penable && pwrite && paddr == 2'd0) reload_q <= pwdata[19:0];
	end

	assign s_tready = !busy;
	assign in_fire = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	escc_ctrl u_ctrl (.clk, .arst_n, .in_fire, .out_free, .busy, .out_load, .cmd, .sts);
	escc_datapath u_dp (.clk, .cmd, .din, .reload(reload_q), .sts, .dout);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (out_load) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (out_load) out_q <= dout;
	end

	assign m_tdata = {6'd0, out_q.msec, out_q.second, out_q.minute, out_q.hour, out_q.day,
		out_q.month, out_q.year, out_q.seconds, out_q.status};
endmodule

// File: hdl/escc_datapath.sv
module escc_datapath import escc_pkg::*; (
	input  logic                clk,
	input  dp_cmd_t             cmd,
	input  in_word_t            din,
	input  logic [RELOAD_W-1:0] reload,
	output dp_sts_t             sts,
	output out_word_t           dout
);
	// phases: 0 day split, 1 time of day, 2 years, 3 months, 4 ms divide, 5 finish
	localparam logic [2:0] PH_DIV = 3'd0, PH_TOD = 3'd1, PH_YEAR = 3'd2, PH_MON = 3'd3,
		PH_MS = 3'd4, PH_END = 3'd5;

	logic [2:0]  ph_q;
	logic        func_q;
	logic [31:0] acc_q;     // mode 0 seconds sum, mode 1 seconds then remainder
	logic [31:0] quo_q;     // day count
	logic [5:0]  cnt_q;
	logic [11:0] year_q;
	logic [11:0] din_year_q;
	logic [3:0]  mon_q;
	logic [3:0]  mtgt_q;
	logic [1:0]  st_q;
	logic [30:0] msn_q;     // ms numerator
	logic [9:0]  msq_q;
	logic [30:0] msr_q;
	logic [4:0]  hr_q;
	logic [5:0]  min_q;
	logic [5:0]  sec_q;
	logic        done_q;
	logic        leap_y;
	logic [30:0] msh;
	logic [50:0] dq_mul;
	logic [25:0] hr_mul;
	logic [19:0] mn_mul;

	assign leap_y = is_leap(year_q);
	assign msh = {msr_q[29:0], msn_q[30]};
	// reciprocal products: days = (s>>7)/675, hours = (r>>4)/225, minutes = (r>>2)/15
	assign dq_mul = 51'(acc_q[31:7]) * 51'd50903317;
	assign hr_mul = 26'(acc_q[16:4]) * 26'd4661;
	assign mn_mul = 20'(acc_q[11:2]) * 20'd1093;

	always_ff @(posedge clk) begin
		done_q <= cmd.step && (ph_q == PH_END);
		if (cmd.load) begin
			func_q <= din.func;
			year_q <= EPOCH_YEAR;
			din_year_q <= din.year;
			mon_q <= 4'd0;
			mtgt_q <= din.month - 4'd1;
			cnt_q <= 6'd0;
			msq_q <= 10'd0;
			msr_q <= 31'd0;
			hr_q <= 5'd0;
			min_q <= 6'd0;
			sec_q <= 6'd0;
			quo_q <= 32'd0;
			if (din.func) begin
				acc_q <= din.seconds;
				ph_q <= PH_DIV;
				st_q <= ST_OK;
				if (reload == '0 || din.divider > reload) msn_q <= 31'd0;
				else msn_q <= 31'(reload - din.divider) * 31'd1000;
			end else begin
				acc_q <= 32'(din.day) * 32'd86400 - 32'd86400 + 32'(din.hour) * 32'd3600
					+ 32'(din.minute) * 32'd60 + 32'(din.second);
				msn_q <= 31'd0;
				if (din.year < EPOCH_YEAR || din.year > LAST_SET_YEAR) begin
					st_q <= ST_BAD_YEAR;
					ph_q <= PH_END;
				end else if (din.month < 4'd1 || din.month > 4'd12) begin
					st_q <= ST_BAD_MONTH;
					ph_q <= PH_END;
				end else begin
					st_q <= ST_OK;
					ph_q <= PH_YEAR;
				end
			end
		end else if (cmd.step) begin
			case (ph_q)
				PH_DIV: begin
					// quotient first, remainder on the next step
					if (cnt_q == 6'd0) begin
						quo_q <= 32'(dq_mul[50:35]);
						cnt_q <= 6'd1;
					end else begin
						acc_q <= acc_q - 32'(quo_q[15:0]) * 32'd86400;
						cnt_q <= 6'd0;
						ph_q <= PH_TOD;
					end
				end
				PH_TOD: begin
					if (cnt_q == 6'd0) begin
						hr_q <= hr_mul[24:20];
					end else if (cnt_q == 6'd1) begin
						acc_q <= acc_q - 32'(hr_q) * 32'd3600;
					end else if (cnt_q == 6'd2) begin
						min_q <= mn_mul[19:14];
					end else begin
						sec_q <= 6'(acc_q[11:0] - 12'(min_q) * 12'd60);
						ph_q <= PH_YEAR;
					end
					cnt_q <= (cnt_q == 6'd3) ? 6'd0 : cnt_q + 6'd1;
				end
				PH_YEAR: begin
					if (func_q) begin
						if (quo_q < (leap_y ? 32'd366 : 32'd365)) begin
							ph_q <= PH_MON;
						end else begin
							quo_q <= quo_q - (leap_y ? 32'd366 : 32'd365);
							year_q <= year_q + 12'd1;
						end
					end else begin
						if (year_q == din_year_q) begin
							ph_q <= PH_MON;
						end else begin
							acc_q <= acc_q + (leap_y ? 32'd31622400 : 32'd31536000);
							year_q <= year_q + 12'd1;
						end
					end
				end
				PH_MON: begin
					if (func_q) begin
						if (mon_q == 4'd11 || quo_q < 32'(month_days(mon_q, leap_y))) begin
							ph_q <= PH_MS;
							cnt_q <= 6'd0;
						end else begin
							quo_q <= quo_q - 32'(month_days(mon_q, leap_y));
							mon_q <= mon_q + 4'd1;
						end
					end else begin
						if (mon_q == mtgt_q) begin
							ph_q <= PH_END;
						end else begin
							acc_q <= acc_q + 32'(month_days(mon_q, leap_y)) * 32'd86400;
							mon_q <= mon_q + 4'd1;
						end
					end
				end
				PH_MS: begin
					// quotient under 1024: ten restoring steps after skipping 21 leading bits
					if (cnt_q < 6'd21) begin
						msr_q <= msh;
					end else if (reload != '0 && {1'b0, msh} >= {12'd0, reload}) begin
						msr_q <= msh - 31'(reload);
						msq_q <= {msq_q[8:0], 1'b1};
					end else begin
						msr_q <= msh;
						msq_q <= {msq_q[8:0], 1'b0};
					end
					msn_q <= {msn_q[29:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd30) ph_q <= PH_END;
				end
				default: begin
					ph_q <= PH_END;
				end
			endcase
		end
	end

	assign sts.done = done_q;
	always_comb begin
		dout = '0;
		if (func_q) begin
			dout.year = year_q;
			dout.month = mon_q + 4'd1;
			dout.day = 5'(quo_q) + 5'd1;
			dout.hour = hr_q;
			dout.minute = min_q;
			dout.second = sec_q;
			dout.msec = msq_q;
		end else begin
			dout.status = st_q;
			dout.seconds = (st_q == ST_OK) ? acc_q : 32'd0;
		end
	end
endmodule

// File: hdl/escc_ctrl.sv
module escc_ctrl import escc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_fire,
	input  logic    out_free,
	output logic    busy,
	output logic    out_load,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);
	localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_WAIT = 2'd2;
	logic [1:0] state_q;

	assign busy = (state_q != S_IDLE);
	assign cmd.load = in_fire;
	assign cmd.step = (state_q == S_RUN);
	assign out_load = (state_q == S_WAIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_RUN;
				S_RUN: if (sts.done) state_q <= S_WAIT;
				S_WAIT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
